/* hdl/ohci_pkg.sv */
package ohci_pkg;

    typedef enum logic [2:0] {
        MODE_READ   = 3'd0,
        MODE_WRITE  = 3'd1,
        MODE_ATTACH = 3'd2,
        MODE_DETACH = 3'd3,
        MODE_TICK   = 3'd4
    } t_mode;

    localparam logic [4:0] REG_REVISION   = 5'd0;
    localparam logic [4:0] REG_CONTROL    = 5'd1;
    localparam logic [4:0] REG_CMD_STATUS = 5'd2;
    localparam logic [4:0] REG_INT_STATUS = 5'd3;
    localparam logic [4:0] REG_INT_ENABLE = 5'd4;
    localparam logic [4:0] REG_INT_DIS    = 5'd5;
    localparam logic [4:0] REG_HCCA       = 5'd6;
    localparam logic [4:0] REG_LIST_FIRST = 5'd7;
    localparam logic [4:0] REG_CTRL_HEAD  = 5'd8;
    localparam logic [4:0] REG_CTRL_CUR   = 5'd9;
    localparam logic [4:0] REG_BULK_HEAD  = 5'd10;
    localparam logic [4:0] REG_BULK_CUR   = 5'd11;
    localparam logic [4:0] REG_LIST_LAST  = 5'd12;
    localparam logic [4:0] REG_FM_INTV    = 5'd13;
    localparam logic [4:0] REG_FM_REM     = 5'd14;
    localparam logic [4:0] REG_FM_NUM     = 5'd15;
    localparam logic [4:0] REG_PER_START  = 5'd16;
    localparam logic [4:0] REG_LS_THRESH  = 5'd17;
    localparam logic [4:0] REG_RH_DESC_A  = 5'd18;
    localparam logic [4:0] REG_RH_DESC_B  = 5'd19;
    localparam logic [4:0] REG_RH_STATUS  = 5'd20;
    localparam logic [4:0] REG_PORT_FIRST = 5'd21;

    localparam logic [1:0] HCFS_RESET   = 2'b00;
    localparam logic [1:0] HCFS_OPER    = 2'b10;
    localparam logic [1:0] HCFS_SUSPEND = 2'b11;

    localparam logic [31:0] INT_SF   = 32'h4;
    localparam logic [31:0] INT_RD   = 32'h8;
    localparam logic [31:0] INT_UE   = 32'h10;
    localparam logic [31:0] INT_RHSC = 32'h40;
    localparam logic [31:0] INT_MIE  = 32'h8000_0000;

    localparam logic [31:0] PT_CCS  = 32'h1;
    localparam logic [31:0] PT_PES  = 32'h2;
    localparam logic [31:0] PT_PSS  = 32'h4;
    localparam logic [31:0] PT_PRS  = 32'h10;
    localparam logic [31:0] PT_PPS  = 32'h100;
    localparam logic [31:0] PT_LSDA = 32'h200;
    localparam logic [31:0] PT_CSC  = 32'h1_0000;
    localparam logic [31:0] PT_PESC = 32'h2_0000;
    localparam logic [31:0] PT_PRSC = 32'h10_0000;
    localparam logic [31:0] PT_WTC  = 32'h1F_0000;

    localparam logic [31:0] RHS_LPS  = 32'h1;
    localparam logic [31:0] RHS_DRWE = 32'h8000;
    localparam logic [31:0] RHS_LPSC = 32'h1_0000;
    localparam logic [31:0] RHS_OCIC = 32'h2_0000;
    localparam logic [31:0] RHS_CRWE = 32'h8000_0000;

    localparam logic [31:0] CS_HCR = 32'h1;
    localparam logic [31:0] CS_SOC = 32'h3_0000;

    localparam logic [31:0] REVISION_VALUE = 32'h10;
    localparam logic [31:0] FM_INTV_RESET  = 32'h2778_2EDF;
    localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
    localparam logic [13:0] FRAME_BIT_TIMES = 14'd12000;

endpackage

/* hdl/ohci_host_controller_registers.sv */
// Channel | Direction | Handshake           | Payload
// input   | in        | i_valid / o_ready   | i_mode, i_address, i_write_data, i_port_index,
//         |           |                     | i_low_speed, i_bit_times_elapsed
// result  | out       | o_valid / i_ready   | o_read_data, o_irq, o_frame_timer_running
//
// Every transfer is processed in the cycle it is accepted: the register state and the
// result register are both updated at that edge, so the result appears in the next cycle.
// One transfer per cycle is sustained; the only limit is the single result register,
// which is refilled in the same cycle it is taken.
// Reset is synchronous and active low; no clearing pass is needed.
// While the result waits, o_ready stays low, so state never runs ahead of results.
module ohci_host_controller_registers #(
    parameter int NUM_PORTS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_address,
    input  logic [31:0] i_write_data,
    input  logic        i_port_index,
    input  logic        i_low_speed,
    input  logic [13:0] i_bit_times_elapsed,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_read_data,
    output logic        o_irq,
    output logic        o_frame_timer_running
);

    // Register state.
    logic [31:0] r_control, n_control;
    logic [31:0] r_cmd_status, n_cmd_status;
    logic [31:0] r_int_status, n_int_status;
    logic [31:0] r_int_enable, n_int_enable;
    logic [31:0] r_hcca, n_hcca;
    logic [31:0] r_list [6];
    logic [31:0] n_list [6];
    logic [31:0] r_fm_intv, n_fm_intv;
    logic        r_frt, n_frt;
    logic [15:0] r_fm_num, n_fm_num;
    logic [13:0] r_per_start, n_per_start;
    logic [11:0] r_ls_thresh, n_ls_thresh;
    logic [31:0] r_rh_desc_a, n_rh_desc_a;
    logic [31:0] r_rh_status, n_rh_status;
    logic [31:0] r_port [NUM_PORTS];
    logic [31:0] n_port [NUM_PORTS];
    logic [NUM_PORTS-1:0] r_present, n_present;
    logic [NUM_PORTS-1:0] r_lowspd, n_lowspd;
    logic        r_timer, n_timer;

    logic        r_out_valid;
    logic [31:0] r_read_data, n_read_data;
    logic        r_irq, r_ftr;

    logic accept;
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    logic [31:0] desc_a_reset;
    assign desc_a_reset = 32'h200 | 32'(NUM_PORTS);

    // The frame-remaining value as it would be read.
    logic [13:0] fi;
    logic [31:0] fm_rem;
    always_comb begin
        fi = r_fm_intv[13:0];
        fm_rem = r_frt ? 32'h8000_0000 : 32'h0;
        if (r_control[7:6] == ohci_pkg::HCFS_OPER
                && i_bit_times_elapsed < ohci_pkg::FRAME_BIT_TIMES
                && i_bit_times_elapsed <= fi) begin
            fm_rem[13:0] = fi - i_bit_times_elapsed;
        end
    end

    logic [5:0]  reg_num;
    logic        aligned;
    logic [4:0]  reg_lo;
    logic        port_hit;
    logic [31:0] port_sel;
    assign reg_num = i_address[7:2];
    assign aligned = (i_address[1:0] == 2'b00);
    assign reg_lo  = reg_num[4:0];
    assign port_hit = (reg_num >= 6'(ohci_pkg::REG_PORT_FIRST))
                   && (reg_num < 6'(32'(ohci_pkg::REG_PORT_FIRST) + NUM_PORTS));

    // Read mux.
    always_comb begin
        port_sel = 32'h0;
        for (int p = 0; p < NUM_PORTS; p++) begin
            if (32'(reg_num) == 32'(ohci_pkg::REG_PORT_FIRST) + p) begin
                port_sel = r_port[p];
            end
        end
        n_read_data = ohci_pkg::ALL_ONES;
        if (aligned) begin
            if (port_hit) begin
                n_read_data = port_sel | ohci_pkg::PT_PPS;
            end else if (reg_num[5] == 1'b0) begin
                unique case (reg_lo)
                    ohci_pkg::REG_REVISION:   n_read_data = ohci_pkg::REVISION_VALUE;
                    ohci_pkg::REG_CONTROL:    n_read_data = r_control;
                    ohci_pkg::REG_CMD_STATUS: n_read_data = r_cmd_status;
                    ohci_pkg::REG_INT_STATUS: n_read_data = r_int_status;
                    ohci_pkg::REG_INT_ENABLE,
                    ohci_pkg::REG_INT_DIS:    n_read_data = r_int_enable;
                    ohci_pkg::REG_HCCA:       n_read_data = r_hcca;
                    ohci_pkg::REG_LIST_FIRST: n_read_data = r_list[0];
                    ohci_pkg::REG_CTRL_HEAD:  n_read_data = r_list[1];
                    ohci_pkg::REG_CTRL_CUR:   n_read_data = r_list[2];
                    ohci_pkg::REG_BULK_HEAD:  n_read_data = r_list[3];
                    ohci_pkg::REG_BULK_CUR:   n_read_data = r_list[4];
                    ohci_pkg::REG_LIST_LAST:  n_read_data = r_list[5];
                    ohci_pkg::REG_FM_INTV:    n_read_data = r_fm_intv;
                    ohci_pkg::REG_FM_REM:     n_read_data = fm_rem;
                    ohci_pkg::REG_FM_NUM:     n_read_data = {16'h0, r_fm_num};
                    ohci_pkg::REG_PER_START:  n_read_data = {18'h0, r_per_start};
                    ohci_pkg::REG_LS_THRESH:  n_read_data = {20'h0, r_ls_thresh};
                    ohci_pkg::REG_RH_DESC_A:  n_read_data = r_rh_desc_a;
                    ohci_pkg::REG_RH_DESC_B:  n_read_data = 32'h0;
                    ohci_pkg::REG_RH_STATUS:  n_read_data = r_rh_status;
                    default:                  n_read_data = ohci_pkg::ALL_ONES;
                endcase
            end
        end
        if (i_mode != ohci_pkg::MODE_READ) begin
            n_read_data = 32'h0;
        end
    end

    // Next-state logic for one event. A soft reset, when triggered, replaces everything
    // except device presence and speed, followed by an attach of present devices.
    logic        do_soft_reset;
    logic [31:0] pv, pold;
    logic [1:0]  olds, news;
    logic        fresh;
    logic [31:0] hs_old;
    logic        irq_next;

    always_comb begin
        n_control    = r_control;
        n_cmd_status = r_cmd_status;
        n_int_status = r_int_status;
        n_int_enable = r_int_enable;
        n_hcca       = r_hcca;
        n_list       = r_list;
        n_fm_intv    = r_fm_intv;
        n_frt        = r_frt;
        n_fm_num     = r_fm_num;
        n_per_start  = r_per_start;
        n_ls_thresh  = r_ls_thresh;
        n_rh_desc_a  = r_rh_desc_a;
        n_rh_status  = r_rh_status;
        n_port       = r_port;
        n_present    = r_present;
        n_lowspd     = r_lowspd;
        n_timer      = r_timer;
        do_soft_reset = 1'b0;
        pv = 32'h0;
        pold = 32'h0;
        olds = r_control[7:6];
        news = i_write_data[7:6];
        fresh = 1'b0;
        hs_old = r_rh_status;

        unique case (i_mode)
            ohci_pkg::MODE_READ: begin
            end
            ohci_pkg::MODE_WRITE: begin
                if (aligned && port_hit) begin
                    for (int p = 0; p < NUM_PORTS; p++) begin
                        if (32'(reg_num) == 32'(ohci_pkg::REG_PORT_FIRST) + p) begin
                            pold = r_port[p];
                            pv = r_port[p] & ~(i_write_data & ohci_pkg::PT_WTC);
                            if ((i_write_data & ohci_pkg::PT_CCS) != 0)
                                pv = pv & ~ohci_pkg::PT_PES;
                            if ((i_write_data & ohci_pkg::PT_PES) != 0) begin
                                if ((pv & ohci_pkg::PT_CCS) == 0) pv = pv | ohci_pkg::PT_CSC;
                                else pv = pv | ohci_pkg::PT_PES;
                            end
                            if ((i_write_data & ohci_pkg::PT_PSS) != 0) begin
                                if ((pv & ohci_pkg::PT_CCS) == 0) pv = pv | ohci_pkg::PT_CSC;
                                else pv = pv | ohci_pkg::PT_PSS;
                            end
                            if ((i_write_data & ohci_pkg::PT_PRS) != 0) begin
                                if ((pv & ohci_pkg::PT_CCS) == 0) begin
                                    pv = pv | ohci_pkg::PT_CSC;
                                end else begin
                                    fresh = (pv & ohci_pkg::PT_PRS) == 0;
                                    pv = pv | ohci_pkg::PT_PRS;
                                    if (fresh) begin
                                        pv = (pv & ~ohci_pkg::PT_PRS)
                                           | ohci_pkg::PT_PES | ohci_pkg::PT_PRSC;
                                    end
                                end
                            end
                            if ((i_write_data & ohci_pkg::PT_LSDA) != 0)
                                pv = pv & ~(ohci_pkg::PT_PPS | ohci_pkg::PT_CCS
                                          | ohci_pkg::PT_PSS | ohci_pkg::PT_PRS);
                            if ((i_write_data & ohci_pkg::PT_PPS) != 0)
                                pv = pv | ohci_pkg::PT_PPS;
                            n_port[p] = pv;
                            if (pv != pold) n_int_status = n_int_status | ohci_pkg::INT_RHSC;
                        end
                    end
                end else if (aligned && reg_num[5] == 1'b0) begin
                    unique case (reg_lo)
                        ohci_pkg::REG_CONTROL: begin
                            n_control = i_write_data;
                            if (olds != news) begin
                                if (news == ohci_pkg::HCFS_OPER) begin
                                    n_timer = 1'b1;
                                    n_int_status = n_int_status | ohci_pkg::INT_SF;
                                end else if (news == ohci_pkg::HCFS_SUSPEND) begin
                                    n_timer = 1'b0;
                                end else if (news == ohci_pkg::HCFS_RESET) begin
                                    do_soft_reset = 1'b1;
                                end
                            end
                        end
                        ohci_pkg::REG_CMD_STATUS: begin
                            n_cmd_status = r_cmd_status | (i_write_data & ~ohci_pkg::CS_SOC);
                            if ((n_cmd_status & ohci_pkg::CS_HCR) != 0) do_soft_reset = 1'b1;
                        end
                        ohci_pkg::REG_INT_STATUS: n_int_status = r_int_status & ~i_write_data;
                        ohci_pkg::REG_INT_ENABLE: n_int_enable = r_int_enable | i_write_data;
                        ohci_pkg::REG_INT_DIS:    n_int_enable = r_int_enable & ~i_write_data;
                        ohci_pkg::REG_HCCA:       n_hcca = i_write_data & 32'hFFFF_FF00;
                        ohci_pkg::REG_CTRL_HEAD: n_list[1] = i_write_data & 32'hFFFF_FFF0;
                        ohci_pkg::REG_CTRL_CUR:  n_list[2] = i_write_data & 32'hFFFF_FFF0;
                        ohci_pkg::REG_BULK_HEAD: n_list[3] = i_write_data & 32'hFFFF_FFF0;
                        ohci_pkg::REG_BULK_CUR:  n_list[4] = i_write_data & 32'hFFFF_FFF0;
                        ohci_pkg::REG_FM_INTV:   n_fm_intv = i_write_data & ~32'hC000;
                        ohci_pkg::REG_PER_START: n_per_start = i_write_data[13:0];
                        ohci_pkg::REG_LS_THRESH: n_ls_thresh = i_write_data[11:0];
                        ohci_pkg::REG_RH_STATUS: begin
                            if ((i_write_data & ohci_pkg::RHS_OCIC) != 0)
                                n_rh_status = n_rh_status & ~ohci_pkg::RHS_OCIC;
                            if ((i_write_data & ohci_pkg::RHS_LPS) != 0)
                                for (int p = 0; p < NUM_PORTS; p++)
                                    n_port[p] = n_port[p] & ~(ohci_pkg::PT_PPS
                                        | ohci_pkg::PT_CCS | ohci_pkg::PT_PSS | ohci_pkg::PT_PRS);
                            if ((i_write_data & ohci_pkg::RHS_LPSC) != 0)
                                for (int p = 0; p < NUM_PORTS; p++)
                                    n_port[p] = n_port[p] | ohci_pkg::PT_PPS;
                            if ((i_write_data & ohci_pkg::RHS_DRWE) != 0)
                                n_rh_status = n_rh_status | ohci_pkg::RHS_DRWE;
                            if ((i_write_data & ohci_pkg::RHS_CRWE) != 0)
                                n_rh_status = n_rh_status & ~ohci_pkg::RHS_DRWE;
                            if (n_rh_status != hs_old)
                                n_int_status = n_int_status | ohci_pkg::INT_RHSC;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ohci_pkg::MODE_ATTACH: begin
                for (int p = 0; p < NUM_PORTS; p++) begin
                    if (32'(i_port_index) == p) begin
                        n_present[p] = 1'b1;
                        n_lowspd[p]  = i_low_speed;
                        pv = r_port[p] | ohci_pkg::PT_CCS | ohci_pkg::PT_CSC;
                        pv = i_low_speed ? (pv | ohci_pkg::PT_LSDA) : (pv & ~ohci_pkg::PT_LSDA);
                        if (r_control[7:6] == ohci_pkg::HCFS_SUSPEND)
                            n_int_status = n_int_status | ohci_pkg::INT_RD;
                        if (pv != r_port[p]) n_int_status = n_int_status | ohci_pkg::INT_RHSC;
                        n_port[p] = pv;
                    end
                end
            end
            ohci_pkg::MODE_DETACH: begin
                for (int p = 0; p < NUM_PORTS; p++) begin
                    if (32'(i_port_index) == p) begin
                        n_present[p] = 1'b0;
                        pv = r_port[p];
                        if ((pv & ohci_pkg::PT_CCS) != 0)
                            pv = (pv & ~ohci_pkg::PT_CCS) | ohci_pkg::PT_CSC;
                        if ((pv & ohci_pkg::PT_PES) != 0)
                            pv = (pv & ~ohci_pkg::PT_PES) | ohci_pkg::PT_PESC;
                        if (pv != r_port[p]) n_int_status = n_int_status | ohci_pkg::INT_RHSC;
                        n_port[p] = pv;
                    end
                end
            end
            ohci_pkg::MODE_TICK: begin
                if (r_timer) begin
                    if (r_hcca == 32'h0) begin
                        n_int_status = n_int_status | ohci_pkg::INT_UE;
                        n_timer = 1'b0;
                    end else if ((r_int_status & ohci_pkg::INT_UE) == 0) begin
                        n_frt = r_fm_intv[31];
                        n_fm_num = r_fm_num + 16'd1;
                        n_int_status = n_int_status | ohci_pkg::INT_SF;
                    end
                end
            end
            default: begin
            end
        endcase

        if (do_soft_reset) begin
            n_timer      = 1'b0;
            n_control    = 32'h0;
            n_cmd_status = 32'h0;
            n_int_status = 32'h0;
            n_int_enable = ohci_pkg::INT_MIE;
            n_hcca       = 32'h0;
            for (int k = 0; k < 6; k++) n_list[k] = 32'h0;
            n_fm_intv    = ohci_pkg::FM_INTV_RESET;
            n_frt        = 1'b0;
            n_fm_num     = 16'h0;
            n_per_start  = 14'h0;
            n_ls_thresh  = 12'h0;
            n_rh_desc_a  = desc_a_reset;
            n_rh_status  = 32'h0;
            for (int p = 0; p < NUM_PORTS; p++) begin
                n_port[p] = 32'h0;
                if (r_present[p]) begin
                    n_port[p] = ohci_pkg::PT_CCS | ohci_pkg::PT_CSC
                              | (r_lowspd[p] ? ohci_pkg::PT_LSDA : 32'h0);
                    n_int_status = n_int_status | ohci_pkg::INT_RHSC;
                end
            end
        end

        irq_next = n_int_enable[31] && ((n_int_status & n_int_enable) != 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control    <= 32'h0;
            r_cmd_status <= 32'h0;
            r_int_status <= 32'h0;
            r_int_enable <= ohci_pkg::INT_MIE;
            r_hcca       <= 32'h0;
            for (int k = 0; k < 6; k++) r_list[k] <= 32'h0;
            r_fm_intv    <= ohci_pkg::FM_INTV_RESET;
            r_frt        <= 1'b0;
            r_fm_num     <= 16'h0;
            r_per_start  <= 14'h0;
            r_ls_thresh  <= 12'h0;
            r_rh_desc_a  <= desc_a_reset;
            r_rh_status  <= 32'h0;
            for (int p = 0; p < NUM_PORTS; p++) r_port[p] <= 32'h0;
            r_present    <= '0;
            r_lowspd     <= '0;
            r_timer      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_control    <= n_control;
                r_cmd_status <= n_cmd_status;
                r_int_status <= n_int_status;
                r_int_enable <= n_int_enable;
                r_hcca       <= n_hcca;
                r_list       <= n_list;
                r_fm_intv    <= n_fm_intv;
                r_frt        <= n_frt;
                r_fm_num     <= n_fm_num;
                r_per_start  <= n_per_start;
                r_ls_thresh  <= n_ls_thresh;
                r_rh_desc_a  <= n_rh_desc_a;
                r_rh_status  <= n_rh_status;
                r_port       <= n_port;
                r_present    <= n_present;
                r_lowspd     <= n_lowspd;
                r_timer      <= n_timer;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data <= n_read_data;
            r_irq       <= irq_next;
            r_ftr       <= n_timer;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_read_data           = r_read_data;
    assign o_irq                 = r_irq;
    assign o_frame_timer_running = r_ftr;

endmodule

/* hdl/ohci_checker.sv */
module ohci_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [2:0]  i_mode,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_read_data
);

    // An accepted transfer always yields a result in the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> o_valid)
        else $error("accepted transfer gave no result");

    // A stalled result holds its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_read_data))
        else $error("stalled result changed");

    // Input is refused only while a result waits untaken.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("ready low without a stalled result");

    // Anything but a read returns zero data.
    a_nonread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_mode != ohci_pkg::MODE_READ) |=> (o_read_data == 32'h0))
        else $error("non-read returned data");

endmodule

bind ohci_host_controller_registers ohci_checker u_ohci_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .i_mode(i_mode), .o_valid(o_valid), .i_ready(i_ready), .o_read_data(o_read_data)
);
